@@ hdl/ias_pkg.sv @@
// Shared types for the integer array sorter.
package ias_pkg;

	typedef enum logic {
		ST_COLLECT,
		ST_DRAIN
	} state_t;

	// Commands broadcast to every cell of the chain.
	typedef struct packed {
		logic insert;
		logic shift_out;
	} cell_ctrl_t;

endpackage

@@ hdl/ias_in_if.sv @@
// Input channel carrying one value of the set and its end-of-set mark.
interface ias_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] sample_value;
	logic               set_end;

	modport source (output valid, output sample_value, output set_end, input ready);
	modport sink (input valid, input sample_value, input set_end, output ready);
endinterface

@@ hdl/ias_out_if.sv @@
// Output channel carrying one sorted value with its flags.
interface ias_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] sorted_value;
	logic               final_item;
	logic               dropped_items;

	modport source (output valid, output sorted_value, output final_item,
		output dropped_items, input ready);
	modport sink (input valid, input sorted_value, input final_item,
		input dropped_items, output ready);
endinterface

@@ hdl/integer_array_sorter.sv @@
// A set of n values is taken at one transaction per cycle; the first
// sorted value is offered the cycle after the set_end transaction.
// Stored values follow at one per cycle while results.ready is high, set by
// the cell chain's shift toward cell zero; no input is taken while a set drains.
// Reset clears all cells to empty and the item count and overflow flag to
// zero at once; the stored values themselves are not cleared.
module integer_array_sorter #(
	parameter int MAX_ITEMS = 64
) (
	input  logic   clk,
	input  logic   arst_n,
	ias_in_if.sink     samples,
	ias_out_if.source  results
);

	ias_pkg::cell_ctrl_t cell_ctrl;
	logic signed [31:0]  cell_value [MAX_ITEMS];
	logic                cell_valid [MAX_ITEMS];
	logic                cell_take  [MAX_ITEMS];

	ias_ctrl #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (samples.valid),
		.in_set_end   (samples.set_end),
		.in_ready     (samples.ready),
		.out_valid    (results.valid),
		.out_ready    (results.ready),
		.final_item   (results.final_item),
		.dropped_items(results.dropped_items),
		.cell_ctrl    (cell_ctrl)
	);

	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		logic               left_take;
		logic signed [31:0] left_value;
		logic               left_valid;
		logic signed [31:0] right_value;
		logic               right_valid;

		if (i == 0) begin : g_first
			assign left_take  = 1'b0;
			assign left_value = '0;
			assign left_valid = 1'b0;
		end else begin : g_inner
			assign left_take  = cell_take[i-1];
			assign left_value = cell_value[i-1];
			assign left_valid = cell_valid[i-1];
		end

		if (i == MAX_ITEMS - 1) begin : g_last
			assign right_value = '0;
			assign right_valid = 1'b0;
		end else begin : g_body
			assign right_value = cell_value[i+1];
			assign right_valid = cell_valid[i+1];
		end

		ias_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (cell_ctrl),
			.new_value  (samples.sample_value),
			.left_take  (left_take),
			.left_value (left_value),
			.left_valid (left_valid),
			.right_value(right_value),
			.right_valid(right_valid),
			.value      (cell_value[i]),
			.valid      (cell_valid[i]),
			.take       (cell_take[i])
		);
	end

	assign results.sorted_value = cell_value[0];

endmodule

@@ hdl/ias_cell.sv @@
// One cell of the sorting chain: holds one value and trades it with its neighbors.
module ias_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  ias_pkg::cell_ctrl_t ctrl,
	input  logic signed [31:0] new_value,
	input  logic               left_take,
	input  logic signed [31:0] left_value,
	input  logic               left_valid,
	input  logic signed [31:0] right_value,
	input  logic               right_valid,
	output logic signed [31:0] value,
	output logic               valid,
	output logic               take
);

	logic signed [31:0] value_q;
	logic               valid_q;

	// The chain is kept ascending with empty cells at the end, so take is
	// low for a prefix of cells and high for the rest.
	assign take  = !valid_q || (new_value < value_q);
	assign value = value_q;
	assign valid = valid_q;

	// A cell that moves its left neighbor's value right also takes over that
	// neighbor's valid bit, so only one empty cell fills per insert.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.insert && take) begin
			valid_q <= left_take ? left_valid : 1'b1;
		end else if (ctrl.shift_out) begin
			valid_q <= right_valid;
		end
	end

	// The first taking cell stores the new value; the cells after it move
	// their left neighbor's value one place right.
	always_ff @(posedge clk) begin
		if (ctrl.insert && take) begin
			value_q <= left_take ? left_value : new_value;
		end else if (ctrl.shift_out) begin
			value_q <= right_value;
		end
	end

endmodule

@@ hdl/ias_ctrl.sv @@
// Collect and drain sequencer with the item count and the overflow flag.
module ias_ctrl #(
	parameter int MAX_ITEMS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_set_end,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                final_item,
	output logic                dropped_items,
	output ias_pkg::cell_ctrl_t cell_ctrl
);

	localparam int CW = $clog2(MAX_ITEMS + 1);

	ias_pkg::state_t state_q, state_next;
	logic [CW-1:0]   count_q;
	logic            overflow_q;
	logic            in_fire;
	logic            out_fire;
	logic            full;

	assign full     = (count_q == CW'(MAX_ITEMS));
	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ias_pkg::ST_COLLECT: begin
				if (in_fire && in_set_end) begin
					state_next = ias_pkg::ST_DRAIN;
				end
			end
			ias_pkg::ST_DRAIN: begin
				if (out_fire && count_q == CW'(1)) begin
					state_next = ias_pkg::ST_COLLECT;
				end
			end
			default: state_next = ias_pkg::ST_COLLECT;
		endcase
	end

	always_comb begin
		in_ready            = 1'b0;
		out_valid           = 1'b0;
		cell_ctrl.insert    = 1'b0;
		cell_ctrl.shift_out = 1'b0;
		unique case (state_q)
			ias_pkg::ST_COLLECT: begin
				in_ready         = 1'b1;
				cell_ctrl.insert = in_fire && !full;
			end
			ias_pkg::ST_DRAIN: begin
				out_valid           = 1'b1;
				cell_ctrl.shift_out = out_fire;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign final_item    = (count_q == CW'(1));
	assign dropped_items = overflow_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ias_pkg::ST_COLLECT;
			count_q    <= '0;
			overflow_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cell_ctrl.insert) begin
				count_q <= count_q + CW'(1);
			end else if (cell_ctrl.shift_out) begin
				count_q <= count_q - CW'(1);
			end
			if (in_fire && full) begin
				overflow_q <= 1'b1;
			end else if (out_fire && count_q == CW'(1)) begin
				overflow_q <= 1'b0;
			end
		end
	end

endmodule
